FILE: hdl/lse_pkg.sv
package lse_pkg;

    // Fixed field widths of the stream words.
    localparam int CHAN_BITS   = 4;
    localparam int SAMPLE_BITS = 16;
    localparam int NEWV_BITS   = 16;
    localparam int OUTV_BITS   = 16;
    localparam int CFG_BITS    = 16;
    localparam int CFG_IDX_BITS = 2;

    // Packed stream widths, rounded up to whole bytes.
    localparam int S_TDATA_BITS = 40;
    localparam int M_TDATA_BITS = 24;

    // Register reset values.
    localparam logic [CFG_BITS-1:0] GAIN_RESET   = 16'd5690;
    localparam logic [CFG_BITS-1:0] LEAK_RESET   = 16'd273;
    localparam logic [CFG_BITS-1:0] THRESH_RESET = 16'd16384;
    localparam logic [CFG_BITS-1:0] SUPPLY_RESET = 16'd36045;

    // Operation carried on the input tuser.
    typedef enum logic {
        OP_INTEGRATE = 1'b0,
        OP_LOAD      = 1'b1
    } t_op;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_GAIN   = 2'd0,
        REG_LEAK   = 2'd1,
        REG_THRESH = 2'd2,
        REG_SUPPLY = 2'd3
    } t_cfg_idx;

    // Configuration as seen by the update datapath.
    typedef struct packed {
        logic [CFG_BITS-1:0] gain;
        logic [CFG_BITS-1:0] leak;
        logic [CFG_BITS-1:0] thresh;
        logic [CFG_BITS-1:0] supply;
    } t_cfg;

endpackage

FILE: hdl/lse_ram.sv
module lse_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/lse_update.sv
module lse_update #(
    parameter int VOLTAGE_BITS = 16
) (
    input  lse_pkg::t_cfg                       i_cfg,
    input  lse_pkg::t_op                        i_op,
    input  logic [VOLTAGE_BITS-1:0]             i_vin,
    input  logic signed [lse_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic [lse_pkg::NEWV_BITS-1:0]       i_new_voltage,
    output logic [VOLTAGE_BITS-1:0]             o_volt,
    output logic                                o_spike,
    output logic                                o_err
);

    // Sum width: the voltage or the 21-bit gain term, plus sign and carries.
    localparam int SW = ((VOLTAGE_BITS > 20) ? VOLTAGE_BITS : 20) + 3;

    logic signed [32:0]             gain_prod;
    logic signed [20:0]             gain_term;
    logic [VOLTAGE_BITS+15:0]       leak_prod;
    logic [VOLTAGE_BITS-1:0]        leak_term;
    logic signed [SW-1:0]           sum;
    logic signed [SW-1:0]           supply_w;
    logic signed [SW-1:0]           vmax_w;
    logic signed [SW-1:0]           top;
    logic signed [SW-1:0]           clamped;
    logic signed [SW-1:0]           thresh_w;
    logic [VOLTAGE_BITS+15:0]       newv_ext;
    logic                           fire;

    // Gain term: signed product, arithmetic shift rounds toward minus infinity.
    assign gain_prod = $signed({1'b0, i_cfg.gain}) * i_sample;
    assign gain_term = gain_prod[32:12];

    // Leak term: unsigned product, truncated.
    assign leak_prod = (VOLTAGE_BITS+16)'(i_cfg.leak) * (VOLTAGE_BITS+16)'(i_vin);
    assign leak_term = leak_prod[VOLTAGE_BITS+15:16];

    // Full-width sum, no wrap.
    assign sum = SW'($signed({1'b0, i_vin})) + SW'(gain_term)
               - SW'($signed({1'b0, leak_term}));

    // Upper clamp is the smaller of the supply limit and the largest voltage.
    assign supply_w = SW'($signed({1'b0, i_cfg.supply}));
    assign vmax_w   = SW'($signed({1'b0, {VOLTAGE_BITS{1'b1}}}));
    assign top      = (supply_w < vmax_w) ? supply_w : vmax_w;

    always_comb begin
        if (sum < 0) begin
            clamped = '0;
        end else if (sum > top) begin
            clamped = top;
        end else begin
            clamped = sum;
        end
    end

    // A bad supply setting suppresses spikes but not integration.
    assign o_err    = (i_cfg.supply <= i_cfg.thresh);
    assign thresh_w = SW'($signed({1'b0, i_cfg.thresh}));
    assign fire     = !o_err && (clamped >= thresh_w);
    assign newv_ext = (VOLTAGE_BITS+16)'(i_new_voltage);

    // Select the new voltage for the operation.
    always_comb begin
        case (i_op)
            lse_pkg::OP_LOAD: begin
                o_volt  = newv_ext[VOLTAGE_BITS-1:0];
                o_spike = 1'b0;
            end
            lse_pkg::OP_INTEGRATE: begin
                o_volt  = fire ? '0 : clamped[VOLTAGE_BITS-1:0];
                o_spike = fire;
            end
            default: begin
                o_volt  = '0;
                o_spike = 1'b0;
            end
        endcase
    end

endmodule

FILE: hdl/lif_spike_encoder.sv
// Each accepted word passes through the compute stage into the output register.
// Throughput: one word per cycle while the output accepts; the channel voltage memory is read
// at acceptance and written when the word leaves the compute stage, with a bypass for
// back-to-back words on the same channel.
// Reset (synchronous, active low) restores register defaults, empties both stages
// and marks every channel voltage as zero through per-channel valid bits.
module lif_spike_encoder #(
    parameter int CHANNEL_COUNT = 16,
    parameter int VOLTAGE_BITS  = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration write port.
    input  logic                                 i_cfg_we,
    input  logic [lse_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [lse_pkg::CFG_BITS-1:0]         i_cfg_data,
    // Input stream.
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [3:0] channel, [19:4] sample, [35:20] new_voltage, [39:36] zero
    input  logic [lse_pkg::S_TDATA_BITS-1:0]     s_axis_tdata,
    // [0] operation
    input  logic [0:0]                           s_axis_tuser,
    // Output stream.
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [3:0] channel_out, [4] spike, [20:5] voltage, [21] config_error, [23:22] zero
    output logic [lse_pkg::M_TDATA_BITS-1:0]     m_axis_tdata
);

    localparam int AW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int VALID_DEPTH = 1 << AW;
    localparam int CB = lse_pkg::CHAN_BITS;

    // Configuration registers.
    lse_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain   <= lse_pkg::GAIN_RESET;
            r_cfg.leak   <= lse_pkg::LEAK_RESET;
            r_cfg.thresh <= lse_pkg::THRESH_RESET;
            r_cfg.supply <= lse_pkg::SUPPLY_RESET;
        end else if (i_cfg_we) begin
            case (lse_pkg::t_cfg_idx'(i_cfg_idx))
                lse_pkg::REG_GAIN:   r_cfg.gain   <= i_cfg_data;
                lse_pkg::REG_LEAK:   r_cfg.leak   <= i_cfg_data;
                lse_pkg::REG_THRESH: r_cfg.thresh <= i_cfg_data;
                lse_pkg::REG_SUPPLY: r_cfg.supply <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input word fields.
    logic [CB-1:0]                          in_chan;
    logic [AW+CB-1:0]                       in_chan_ext;
    logic [AW-1:0]                          in_addr;
    logic                                   in_range;
    logic                                   acc_in;

    assign in_chan     = s_axis_tdata[3:0];
    assign in_chan_ext = (AW+CB)'(in_chan);
    assign in_addr     = in_chan_ext[AW-1:0];
    assign in_range    = (32'(in_chan) < CHANNEL_COUNT);
    assign acc_in      = s_axis_tvalid && s_axis_tready;

    // Compute stage registers.
    logic                                   r_s1_valid;
    lse_pkg::t_op                           r_s1_op;
    logic [CB-1:0]                          r_s1_chan;
    logic [AW-1:0]                          r_s1_addr;
    logic                                   r_s1_range;
    logic signed [lse_pkg::SAMPLE_BITS-1:0] r_s1_sample;
    logic [lse_pkg::NEWV_BITS-1:0]          r_s1_newv;
    logic                                   r_rd_valid;
    logic                                   r_byp_hit;
    logic [VOLTAGE_BITS-1:0]                r_byp_volt;
    logic [VALID_DEPTH-1:0]                 r_chan_valid;

    // Output register.
    logic                                   r_out_valid;
    logic [lse_pkg::M_TDATA_BITS-1:0]       r_out_data;

    logic                                   adv;
    logic                                   wr_en;
    logic [VOLTAGE_BITS-1:0]                ram_rdata;
    logic [VOLTAGE_BITS-1:0]                vin;
    logic [VOLTAGE_BITS-1:0]                upd_volt;
    logic                                   upd_spike;
    logic                                   upd_err;
    logic [VOLTAGE_BITS+15:0]               volt_ext;
    logic [lse_pkg::OUTV_BITS-1:0]          res_volt;
    logic                                   res_spike;
    logic [lse_pkg::M_TDATA_BITS-1:0]       n_out_data;

    // Stage hand-off: the compute stage moves on when the output register frees up.
    assign adv           = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || adv;
    assign wr_en         = adv && r_s1_range;

    // Voltage store.
    lse_ram #(
        .WIDTH (VOLTAGE_BITS),
        .DEPTH (CHANNEL_COUNT)
    ) u_volt_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_s1_addr),
        .i_wdata (upd_volt),
        .i_re    (acc_in),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    // Capture the word, the valid bit and any same-edge write to the same channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (acc_in) begin
            r_s1_valid <= 1'b1;
        end else if (adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_s1_op     <= lse_pkg::t_op'(s_axis_tuser[0]);
            r_s1_chan   <= in_chan;
            r_s1_addr   <= in_addr;
            r_s1_range  <= in_range;
            r_s1_sample <= s_axis_tdata[19:4];
            r_s1_newv   <= s_axis_tdata[35:20];
            r_rd_valid  <= in_range && r_chan_valid[in_addr];
            r_byp_hit   <= wr_en && (r_s1_addr == in_addr);
            r_byp_volt  <= upd_volt;
        end
    end

    // A channel reads as zero until it is first written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_valid <= '0;
        end else if (wr_en) begin
            r_chan_valid[r_s1_addr] <= 1'b1;
        end
    end

    assign vin = r_byp_hit ? r_byp_volt : (r_rd_valid ? ram_rdata : '0);

    lse_update #(
        .VOLTAGE_BITS (VOLTAGE_BITS)
    ) u_update (
        .i_cfg         (r_cfg),
        .i_op          (r_s1_op),
        .i_vin         (vin),
        .i_sample      (r_s1_sample),
        .i_new_voltage (r_s1_newv),
        .o_volt        (upd_volt),
        .o_spike       (upd_spike),
        .o_err         (upd_err)
    );

    // Out-of-range channels report zero and leave state alone.
    assign volt_ext   = (VOLTAGE_BITS+16)'(upd_volt);
    assign res_volt   = r_s1_range ? volt_ext[15:0] : '0;
    assign res_spike  = r_s1_range && upd_spike;
    assign n_out_data = {2'b00, upd_err, res_volt, res_spike, r_s1_chan};

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

FILE: dv/lif_spike_checker.sv
`timescale 1ns / 100ps

// Watches the register port and both streams of the spike encoder. It keeps its own
// copy of the registers and of every channel's membrane voltage, works out the result
// word of each accepted input word, and compares the result words in arrival order.
module lif_spike_checker #(
    parameter int CHANNEL_COUNT = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [lse_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [lse_pkg::CFG_BITS-1:0]         i_cfg_data,
    input  logic                                 s_axis_tvalid,
    input  logic                                 s_axis_tready,
    // [3:0] channel, [19:4] sample, [35:20] new_voltage, [39:36] zero
    input  logic [lse_pkg::S_TDATA_BITS-1:0]     s_axis_tdata,
    // [0] operation
    input  logic [0:0]                           s_axis_tuser,
    input  logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [3:0] channel_out, [4] spike, [20:5] voltage, [21] config_error, [23:22] zero
    input  logic [lse_pkg::M_TDATA_BITS-1:0]     m_axis_tdata,
    output int                                   o_failures,
    output int                                   o_outstanding
);

    // One result word, laid out as on the output stream (last member in the low bits).
    typedef struct packed {
        logic                          cfg_err;
        logic [lse_pkg::OUTV_BITS-1:0] volt;
        logic                          spike;
        logic [lse_pkg::CHAN_BITS-1:0] chan;
    } t_spike_word;

    lse_pkg::t_cfg                 regs;
    logic [lse_pkg::OUTV_BITS-1:0] membrane [CHANNEL_COUNT];
    t_spike_word                   spike_words [$];
    int                            fails;

    // One neuron update: leaky integration with clamp and hard reset, or a direct load.
    function automatic t_spike_word step_membrane(
        input lse_pkg::t_op                          op,
        input logic [lse_pkg::CHAN_BITS-1:0]         chan,
        input logic signed [lse_pkg::SAMPLE_BITS-1:0] smp,
        input logic [lse_pkg::NEWV_BITS-1:0]         nv
    );
        t_spike_word w;
        longint      v;
        longint      gain_part;
        longint      leak_part;
        longint      total;
        w.chan    = chan;
        w.spike   = 1'b0;
        w.volt    = '0;
        w.cfg_err = (regs.supply <= regs.thresh);
        if (int'(chan) < CHANNEL_COUNT) begin
            if (op == lse_pkg::OP_LOAD) begin
                w.volt = nv;
            end else begin
                v = longint'(membrane[chan]);
                // The gain term rounds toward minus infinity, the leak term truncates.
                gain_part = (longint'(regs.gain) * longint'(smp)) >>> 12;
                leak_part = (longint'(regs.leak) * v) >> 16;
                total = v + gain_part - leak_part;
                if (total < 0) begin
                    total = 0;
                end
                if (total > longint'(regs.supply)) begin
                    total = longint'(regs.supply);
                end
                w.volt = total[lse_pkg::OUTV_BITS-1:0];
                // A bad supply setting blocks firing but not integration.
                if (!w.cfg_err && w.volt >= regs.thresh) begin
                    w.spike = 1'b1;
                    w.volt  = '0;
                end
            end
            membrane[chan] = w.volt;
        end
        return w;
    endfunction

    // Results are checked before new words are predicted, and register writes come last,
    // so a word accepted at an edge sees the registers from before that edge.
    always @(posedge i_clk) begin : watch
        t_spike_word seen;
        t_spike_word want;
        t_spike_word pred;
        if (!i_rst_n) begin
            regs = '{gain: lse_pkg::GAIN_RESET, leak: lse_pkg::LEAK_RESET,
                     thresh: lse_pkg::THRESH_RESET, supply: lse_pkg::SUPPLY_RESET};
            foreach (membrane[i]) begin
                membrane[i] = '0;
            end
            spike_words.delete();
            fails = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen = m_axis_tdata[$bits(t_spike_word)-1:0];
                if (spike_words.size() == 0) begin
                    if (fails < 10) begin
                        $display("%0t: result word with nothing pending: %s%0d %0b %0d %0b",
                                 $realtime, "ch/spike/v/err=", seen.chan, seen.spike,
                                 seen.volt, seen.cfg_err);
                    end
                    fails++;
                end else begin
                    want = spike_words.pop_front();
                    if (seen.chan != want.chan || seen.spike != want.spike ||
                        seen.volt != want.volt || seen.cfg_err != want.cfg_err) begin
                        if (fails < 10) begin
                            $display("%0t: mismatch: expected ch=%0d spike=%0b v=%0d err=%0b,",
                                     $realtime, want.chan, want.spike, want.volt,
                                     want.cfg_err);
                            $display("    got ch=%0d spike=%0b v=%0d err=%0b",
                                     seen.chan, seen.spike, seen.volt, seen.cfg_err);
                        end
                        fails++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pred = step_membrane(lse_pkg::t_op'(s_axis_tuser[0]), s_axis_tdata[3:0],
                                     s_axis_tdata[19:4], s_axis_tdata[35:20]);
                spike_words = {spike_words, pred};
            end
            if (i_cfg_we) begin
                case (lse_pkg::t_cfg_idx'(i_cfg_idx))
                    lse_pkg::REG_GAIN:   regs.gain   = i_cfg_data;
                    lse_pkg::REG_LEAK:   regs.leak   = i_cfg_data;
                    lse_pkg::REG_THRESH: regs.thresh = i_cfg_data;
                    lse_pkg::REG_SUPPLY: regs.supply = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_failures    <= fails;
        o_outstanding <= spike_words.size();
    end

endmodule

FILE: dv/lif_spike_encoder_test.sv
`timescale 1ns / 100ps

// Drives the spike encoder with a short directed sequence and then with random words
// under several register settings, with random gaps on the input and random stalls on
// the output. The checker beside the block does all prediction and comparison.
module lif_spike_encoder_test;

    localparam int STALL_LIMIT = 2000;
    localparam int CB = lse_pkg::CHAN_BITS;
    localparam int SB = lse_pkg::SAMPLE_BITS;
    localparam int NB = lse_pkg::NEWV_BITS;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_we = 1'b0;
    logic [lse_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx = '0;
    logic [lse_pkg::CFG_BITS-1:0]        i_cfg_data = '0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [lse_pkg::S_TDATA_BITS-1:0]    s_axis_tdata = '0;
    logic [0:0]                          s_axis_tuser = '0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [lse_pkg::M_TDATA_BITS-1:0]    m_axis_tdata;
    logic                                no_idle = 1'b0;
    int                                  failures;
    int                                  outstanding;
    int                                  quiet_cycles = 0;

    // Register settings of the random phases: reset values, both error cases at the
    // extremes, heavy leak, a tiny voltage window, one random draw and a mild setting.
    lse_pkg::t_cfg setups [7] = '{
        '{lse_pkg::GAIN_RESET, lse_pkg::LEAK_RESET, lse_pkg::THRESH_RESET,
          lse_pkg::SUPPLY_RESET},
        '{16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF},
        '{16'h0000, 16'hFFFF, 16'h0000, 16'h0000},
        '{16'd4096, 16'hFFFF, 16'd20000, 16'hFFFF},
        '{16'd1000, 16'd100, 16'd1, 16'd2},
        '{16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd2048, 16'd1024, 16'd12000, 16'd30000}
    };

    lif_spike_encoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    lif_spike_checker spike_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_failures    (failures),
        .o_outstanding (outstanding)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Output side: after each accepted word, hold tready low for a random stall.
    always @(posedge i_clk) begin : sink_pace
        int unsigned draw;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            draw = 0;
        end else if (m_axis_tready) begin
            if (m_axis_tvalid) begin
                draw = no_idle ? 0 : $urandom_range(0, 8);
                if (draw != 0) begin
                    m_axis_tready <= 1'b0;
                end
            end
        end else if (draw <= 1) begin
            m_axis_tready <= 1'b1;
            draw = 0;
        end else begin
            draw = draw - 1;
        end
    end

    // Watchdog: too long without any word moving ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Send one input word after a random gap and wait until it is taken.
    task automatic send_word(input lse_pkg::t_op op, input logic [CB-1:0] chan,
                             input logic [SB-1:0] smp, input logic [NB-1:0] nv);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, nv, smp, chan};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Stop sending and wait until every result word has come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // Write all four registers, one per cycle.
    task automatic program_regs(input lse_pkg::t_cfg setting);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= lse_pkg::REG_GAIN;
        i_cfg_data <= setting.gain;
        @(posedge i_clk);
        i_cfg_idx  <= lse_pkg::REG_LEAK;
        i_cfg_data <= setting.leak;
        @(posedge i_clk);
        i_cfg_idx  <= lse_pkg::REG_THRESH;
        i_cfg_data <= setting.thresh;
        @(posedge i_clk);
        i_cfg_idx  <= lse_pkg::REG_SUPPLY;
        i_cfg_data <= setting.supply;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        lse_pkg::t_op   op;
        logic [CB-1:0]  chan;
        logic [SB-1:0]  smp;
        logic [NB-1:0]  nv;
        int unsigned    roll;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        setups[5] = lse_pkg::t_cfg'({$urandom(), $urandom()});

        // Directed words under the reset settings, back to back.
        no_idle <= 1'b1;
        send_word(lse_pkg::OP_LOAD,      4'd0,  16'h0000, 16'h0000);
        send_word(lse_pkg::OP_LOAD,      4'd15, 16'hFFFF, 16'hFFFF);
        // A full-scale voltage clamps to the supply and fires.
        send_word(lse_pkg::OP_INTEGRATE, 4'd15, 16'h0000, 16'h0000);
        send_word(lse_pkg::OP_INTEGRATE, 4'd1,  16'h7FFF, 16'h0000);
        send_word(lse_pkg::OP_INTEGRATE, 4'd1,  16'h8000, 16'h0000);
        // Smallest samples of both signs; the negative one rounds down and clamps at zero.
        send_word(lse_pkg::OP_INTEGRATE, 4'd2,  16'h0001, 16'h0000);
        send_word(lse_pkg::OP_INTEGRATE, 4'd2,  16'hFFFF, 16'h0000);
        // Just below and just above the threshold after leak.
        send_word(lse_pkg::OP_LOAD,      4'd3,  16'h0000, 16'd16383);
        send_word(lse_pkg::OP_INTEGRATE, 4'd3,  16'h0000, 16'h0000);
        send_word(lse_pkg::OP_LOAD,      4'd4,  16'h0000, 16'd16500);
        send_word(lse_pkg::OP_INTEGRATE, 4'd4,  16'h0000, 16'h0000);
        // Repeated updates of one channel exercise the bypass path.
        repeat (4) send_word(lse_pkg::OP_INTEGRATE, 4'd5, 16'd3000, 16'h0000);

        // Supply equal to threshold: error flag set, no firing, loads stay unclamped.
        wait_drained();
        program_regs('{lse_pkg::GAIN_RESET, lse_pkg::LEAK_RESET, lse_pkg::SUPPLY_RESET,
                       lse_pkg::SUPPLY_RESET});
        send_word(lse_pkg::OP_INTEGRATE, 4'd6,  16'h7FFF, 16'h0000);
        send_word(lse_pkg::OP_LOAD,      4'd6,  16'h0000, 16'hFFFF);
        send_word(lse_pkg::OP_INTEGRATE, 4'd6,  16'h0000, 16'h0000);

        // No leak and unit gain: landing exactly on the threshold fires.
        wait_drained();
        program_regs('{16'd4096, 16'd0, 16'd16384, 16'hFFFF});
        send_word(lse_pkg::OP_LOAD,      4'd7,  16'h0000, 16'd16384);
        send_word(lse_pkg::OP_INTEGRATE, 4'd7,  16'h0000, 16'h0000);
        send_word(lse_pkg::OP_LOAD,      4'd8,  16'h0000, 16'd16383);
        send_word(lse_pkg::OP_INTEGRATE, 4'd8,  16'h0000, 16'h0000);
        send_word(lse_pkg::OP_INTEGRATE, 4'd8,  16'h0001, 16'h0000);

        // Random words, one phase per register setting.
        foreach (setups[p]) begin
            wait_drained();
            program_regs(setups[p]);
            for (int n = 0; n < 105; n++) begin
                if (n % 35 == 0) begin
                    no_idle <= ($urandom_range(0, 3) == 0);
                end
                roll = $urandom_range(0, 99);
                op   = lse_pkg::OP_INTEGRATE;
                chan = CB'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 3)
                                                       : $urandom_range(0, 15));
                nv   = NB'($urandom());
                smp  = SB'($urandom());
                if (roll < 12) begin
                    op = lse_pkg::OP_LOAD;
                    if (roll < 6) begin
                        nv = NB'(32'(setups[p].thresh) + $urandom_range(0, 63) - 32);
                    end
                end else if (roll < 55) begin
                    // Small positive samples build up toward the threshold.
                    smp = SB'($urandom_range(0, 6000));
                end else if (roll < 75) begin
                    smp = SB'($urandom());
                end else if (roll < 90) begin
                    smp = SB'(-$urandom_range(0, 6000));
                end else begin
                    case ($urandom_range(0, 3))
                        0: smp = 16'h7FFF;
                        1: smp = 16'h8000;
                        2: smp = 16'hFFFF;
                        default: smp = 16'h0000;
                    endcase
                end
                send_word(op, chan, smp, nv);
            end
        end

        // Let the pipeline settle so any stray result word would be seen.
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (failures == 0 && outstanding == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/lse_pkg.sv
hdl/lse_ram.sv
hdl/lse_update.sv
hdl/lif_spike_encoder.sv
dv/lif_spike_checker.sv
dv/lif_spike_encoder_test.sv
